/* rtl/accel_window_variance_motion_defines.svh */
// Assertion macros used by the checker file
`ifndef ACCEL_WINDOW_VARIANCE_MOTION_DEFINES_SVH
`define ACCEL_WINDOW_VARIANCE_MOTION_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AWVM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define AWVM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/awvm_pkg.sv */
// Types and constants of the window variance motion detector
`timescale 1ns / 1ps

package awvm_pkg;

	localparam int COORD_W  = 8;
	localparam int SAMPLE_W = 3 * COORD_W;
	localparam int SQ_W     = 16;
	localparam int RAD_W    = 32;
	localparam int ROOT_W   = 16;
	localparam int THR_W    = 16;
	localparam int THR_FRAC = 8;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [0:0] REG_MOTION_THRESH = 1'b0;
	localparam logic [THR_W-1:0] THR_RESET = 16'd128;

	typedef enum logic [1:0] {
		MS_INSUFFICIENT = 2'd0,
		MS_STATIONARY   = 2'd1,
		MS_MOVING       = 2'd2
	} motion_state_t;

endpackage

/* rtl/awvm_if.sv */
// Request channels: accelerometer samples in, motion decisions out
`timescale 1ns / 1ps

interface awvm_sample_if import awvm_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] accel_x;
	logic signed [COORD_W-1:0] accel_y;
	logic signed [COORD_W-1:0] accel_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface awvm_result_if ();
	logic       valid;
	logic       ready;
	logic [1:0] motion_state;

	modport source (output valid, output motion_state, input ready);
	modport sink (input valid, input motion_state, output ready);
endinterface

/* rtl/awvm_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module awvm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 10
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/awvm_isqrt.sv */
// Bit-serial floor square root, two radicand bits per cycle
`timescale 1ns / 1ps

module awvm_isqrt import awvm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int CNT_W = $clog2(ROOT_W);
	localparam int REM_W = ROOT_W + 2;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [REM_W+1:0]  rem_sh;
	logic [REM_W+1:0]  trial;
	logic              fits;

	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(ROOT_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* rtl/accel_window_variance_motion.sv */
// Top level: sliding-window variance motion detector
`timescale 1ns / 1ps
//
// Usage
//   accel (sink): one signed 8-bit x/y/z accelerometer sample per request.
//   motion (source): one motion_state per sample: 0 insufficient data,
//     1 stationary, 2 moving.
//   APB port: register 0 at byte address 0 is motion_threshold_q8
//     (unsigned Q8.8, reset 0.5). Write only while the block is idle.
// Operation
//   A sample is stored in a window RAM of WINDOW_DEPTH entries. During
//   warm-up the sequencer goes straight to its done state. Otherwise the
//   sequencer walks the window: per entry one RAM read, the shared squarer
//   for x^2+y^2+z^2 one coordinate at a time, the bit-serial square root
//   unit and an accumulate step. Final steps then form the decision.
//   accel.ready is high only when idle, so a new sample is taken only after
//   the decision on the last one has been passed to the output register.
// Reset and stalls
//   arst_n clears pointer, fill flag and per-entry valid bits; an entry
//   never written reads as zero. The threshold returns to 0.5.
//   The result sits in an output register; a new sample is accepted while
//   it waits, and a finished decision holds until motion.ready frees it.
module accel_window_variance_motion import awvm_pkg::*; #(
	parameter int WINDOW_DEPTH = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	awvm_sample_if.sink           accel,
	awvm_result_if.source         motion,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CW      = $clog2(WINDOW_DEPTH);
	localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W   = ROOT_W + CW;
	localparam int SUMSQ_W = 2 * ROOT_W + CW;
	localparam int DIFF_W  = 2 * SUM_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW_DEPTH - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_SQX,
		ST_SQY,
		ST_SQZ,
		ST_ROOT,
		ST_WAIT,
		ST_ACC,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    wp_q;
	logic                full_q;
	logic [WINDOW_DEPTH-1:0] valid_q;
	logic [IDX_W-1:0]    idx_q;
	motion_state_t       res_q;
	logic                out_valid_q;
	motion_state_t       out_state_q;
	logic [THR_W-1:0]    thr_q;

	// datapath registers
	logic [SQ_W-1:0]     sq_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUMSQ_W-1:0]  sumsq_q;
	logic [DIFF_W-1:0]   sqsum_q;
	logic [DIFF_W-1:0]   lhs_q;
	logic [DIFF_W-1:0]   diff_q;
	logic [DIFF_W-1:0]   rhs_q;

	logic                in_acc;
	logic                out_free;
	logic                out_load;
	logic                warmup;
	logic                cfg_wr;
	logic [SAMPLE_W-1:0] wr_sample;
	logic [SAMPLE_W-1:0] rd_data;
	logic [SAMPLE_W-1:0] entry;
	logic [COORD_W-1:0]  coord;
	logic [COORD_W-1:0]  coord_abs;
	logic [SUM_W-1:0]    sqr_op;
	logic [DIFF_W-1:0]   sqr_prod;
	logic                sqrt_start;
	logic                sqrt_done;
	logic [ROOT_W-1:0]   root;

	assign in_acc   = accel.valid && accel.ready;
	assign out_free = !out_valid_q || motion.ready;
	assign out_load = (state_q == ST_DONE) && out_free;
	assign cfg_wr   = psel && penable && pwrite && pready;

	// still warming up after this sample lands
	assign warmup = !full_q &&
		(({1'b0, wp_q} + 1'b1) < (IDX_W + 1)'(WINDOW_DEPTH - 1));

	assign wr_sample = {accel.accel_z, accel.accel_y, accel.accel_x};

	awvm_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (in_acc),
		.waddr (wp_q),
		.wdata (wr_sample),
		.re    (state_q == ST_RD),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	// unwritten entries count as a zero sample
	assign entry = valid_q[idx_q] ? rd_data : '0;

	always_comb begin
		case (state_q)
			ST_SQY:  coord = entry[2*COORD_W-1 -: COORD_W];
			ST_SQZ:  coord = entry[3*COORD_W-1 -: COORD_W];
			default: coord = entry[COORD_W-1:0];
		endcase
	end

	assign coord_abs = coord[COORD_W-1] ? COORD_W'(~coord + 1'b1) : coord;

	// shared squarer
	always_comb begin
		case (state_q)
			ST_SQX, ST_SQY, ST_SQZ: sqr_op = SUM_W'(coord_abs);
			ST_ACC:                 sqr_op = SUM_W'(root);
			ST_FIN1:                sqr_op = sum_q;
			default:                sqr_op = '0;
		endcase
	end

	assign sqr_prod = sqr_op * sqr_op;

	assign sqrt_start = (state_q == ST_ROOT);

	awvm_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({sq_q, 16'h0000}),
		.done     (sqrt_done),
		.root     (root)
	);

	// sequencer, window bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			full_q      <= 1'b0;
			valid_q     <= '0;
			idx_q       <= '0;
			res_q       <= MS_INSUFFICIENT;
			out_valid_q <= 1'b0;
			out_state_q <= MS_INSUFFICIENT;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && motion.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						valid_q[wp_q] <= 1'b1;
						idx_q         <= '0;
						if (wp_q == LAST) begin
							wp_q   <= '0;
							full_q <= 1'b1;
						end else begin
							wp_q <= wp_q + 1'b1;
						end
						if (warmup) begin
							res_q   <= MS_INSUFFICIENT;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD:   state_q <= ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_SQZ;
				ST_SQZ:  state_q <= ST_ROOT;
				ST_ROOT: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (sqrt_done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (idx_q == LAST) begin
						state_q <= ST_FIN1;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_FIN1: state_q <= ST_FIN2;
				ST_FIN2: state_q <= ST_FIN3;
				ST_FIN3: begin
					res_q   <= (diff_q > rhs_q) ? MS_MOVING : MS_STATIONARY;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_state_q <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sum_q   <= '0;
				sumsq_q <= '0;
			end
			ST_SQX: sq_q <= SQ_W'(sqr_prod);
			ST_SQY, ST_SQZ: sq_q <= sq_q + SQ_W'(sqr_prod);
			ST_ACC: begin
				sum_q   <= sum_q + SUM_W'(root);
				sumsq_q <= sumsq_q + SUMSQ_W'(sqr_prod);
			end
			ST_FIN1: begin
				// N*sum(m^2) and (sum m)^2
				sqsum_q <= sqr_prod;
				lhs_q   <= DIFF_W'(sumsq_q) * DIFF_W'(WINDOW_DEPTH);
			end
			ST_FIN2: begin
				diff_q <= (lhs_q >= sqsum_q) ? (lhs_q - sqsum_q) : '0;
				rhs_q  <= DIFF_W'({thr_q, THR_FRAC'(0)}) *
					DIFF_W'(WINDOW_DEPTH * WINDOW_DEPTH);
			end
			default: ;
		endcase
	end

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr && (paddr[2:2] == REG_MOTION_THRESH)) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2:2] == REG_MOTION_THRESH) ? APB_DATA_W'(thr_q) : '0;

	assign accel.ready         = (state_q == ST_IDLE);
	assign motion.valid        = out_valid_q;
	assign motion.motion_state = out_state_q;

endmodule

/* rtl/awvm_checker.sv */
// Port-level checks on the motion detector, bound to the top level
`timescale 1ns / 1ps
`include "accel_window_variance_motion_defines.svh"

module awvm_checker import awvm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_state
);

	`AWVM_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "accepted a second sample while busy")
	`AWVM_ASSERT_SAME(a_state_code, out_valid, out_state == MS_INSUFFICIENT || out_state == MS_STATIONARY || out_state == MS_MOVING, "invalid motion state code")
	`AWVM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_state), "stalled result changed")

endmodule

bind accel_window_variance_motion awvm_checker u_awvm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (accel.valid),
	.in_ready  (accel.ready),
	.out_valid (motion.valid),
	.out_ready (motion.ready),
	.out_state (motion.motion_state)
);
